[rtl/off_ground_detector_core_macros.svh]
// Assertion macros shared by the off-ground detector checks.
// Each macro expects clk and rst_n in scope where it is used.
`ifndef OFF_GROUND_DETECTOR_CORE_MACROS_SVH
`define OFF_GROUND_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, idle while in reset.
`define OGD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("off_ground_detector_core: same-cycle check failed");

// Next-cycle implication, idle while in reset.
`define OGD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("off_ground_detector_core: next-cycle check failed");

`endif

[rtl/ogd_pkg.sv]
// Types and fixed constants for the off-ground detector.
// No dependencies; imported by the core module and the checker.
package ogd_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic [15:0]        cfg_data_t;
    typedef logic [2:0]         cfg_index_t;
    typedef logic [8:0]         weight_t;
    typedef logic [7:0]         count_t;
    typedef logic signed [9:0]  count_wide_t;

    // Register indexes on the configuration port
    localparam cfg_index_t CFG_FILTER_WEIGHT  = 3'd0;
    localparam cfg_index_t CFG_THRESHOLD_NEAR = 3'd1;
    localparam cfg_index_t CFG_THRESHOLD_MID  = 3'd2;
    localparam cfg_index_t CFG_THRESHOLD_FAR  = 3'd3;
    localparam cfg_index_t CFG_COUNT_LIMIT    = 3'd4;
    localparam cfg_index_t CFG_LANDING_DROP   = 3'd5;

    // Reset values of the registers
    localparam weight_t RST_FILTER_WEIGHT  = 9'd51;
    localparam sample_t RST_THRESHOLD_NEAR = -16'sd2048;
    localparam sample_t RST_THRESHOLD_MID  = -16'sd2176;
    localparam sample_t RST_THRESHOLD_FAR  = -16'sd2304;
    localparam count_t  RST_COUNT_LIMIT    = 8'd200;
    localparam count_t  RST_LANDING_DROP   = 8'd30;

    // Filter weight of one in Q1.8
    localparam weight_t WEIGHT_ONE = 9'd256;

    // Evidence increments per band
    localparam count_wide_t GROW_MID  = 10'sd4;
    localparam count_wide_t GROW_FAR  = 10'sd5;
    localparam count_wide_t GROW_DEEP = 10'sd10;

endpackage

[rtl/off_ground_detector_core.sv]
// Off-ground detector: low-pass filter on vertical acceleration and a
// tiered evidence counter. The block takes one request per clock cycle with
// no gaps while the result is not stalled; each request passes through the
// input register, then the result register, before its result appears on
// the outputs. This structure is set by the filter's feedback loop: the new
// filtered value, computed with one 10x17 multiplier from the sample and the
// previous filtered value, must be ready for the next sample in the following
// cycle, so the filter and counter update are combinational logic between
// the input and result registers.
// A stalled result is held while the input register keeps accepting until
// it, too, is full. Configuration is taken from a plain write port and must
// only be written while no request is in flight.
module off_ground_detector_core (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_write,
    input  ogd_pkg::cfg_index_t cfg_index,
    input  ogd_pkg::cfg_data_t cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  ogd_pkg::sample_t   accel_z,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output ogd_pkg::sample_t   filtered_g,
    output logic               off_ground,
    output ogd_pkg::count_t    evidence_count
);

    import ogd_pkg::*;

    // Configuration registers
    weight_t filter_weight_reg;
    sample_t threshold_near_reg;
    sample_t threshold_mid_reg;
    sample_t threshold_far_reg;
    count_t  count_limit_reg;
    count_t  landing_drop_reg;

    // Input register
    logic    in_full_reg;
    sample_t sample_reg;

    // Detector state
    sample_t last_filtered_reg;
    sample_t last_filtered_next;
    count_t  count_reg;
    count_t  count_next;
    logic    flag_reg;
    logic    flag_next;

    // Result register
    logic    out_valid_reg;
    sample_t filtered_g_reg;
    logic    off_ground_reg;
    count_t  evidence_count_reg;

    // Handshake
    logic    in_accept;
    logic    advance;

    // Datapath
    weight_t             weight_eff;
    logic signed [16:0]  diff;
    logic signed [26:0]  prod;
    logic signed [26:0]  sum;
    count_wide_t         cnt_step;
    count_wide_t         cnt_sat;
    count_wide_t         limit_ext;

    // Move the held request into the result register whenever that is free
    // or being emptied this cycle.
    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_weight_reg  <= RST_FILTER_WEIGHT;
            threshold_near_reg <= RST_THRESHOLD_NEAR;
            threshold_mid_reg  <= RST_THRESHOLD_MID;
            threshold_far_reg  <= RST_THRESHOLD_FAR;
            count_limit_reg    <= RST_COUNT_LIMIT;
            landing_drop_reg   <= RST_LANDING_DROP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FILTER_WEIGHT:  filter_weight_reg  <= cfg_data[8:0];
                CFG_THRESHOLD_NEAR: threshold_near_reg <= cfg_data;
                CFG_THRESHOLD_MID:  threshold_mid_reg  <= cfg_data;
                CFG_THRESHOLD_FAR:  threshold_far_reg  <= cfg_data;
                CFG_COUNT_LIMIT:    count_limit_reg    <= cfg_data[7:0];
                CFG_LANDING_DROP:   landing_drop_reg   <= cfg_data[7:0];
                default:            ; // drop writes to unused indexes
            endcase
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (in_accept)
            in_full_reg <= 1'b1;
        else if (advance)
            in_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            sample_reg <= accel_z;
    end

    // ---------------- filter ----------------
    // (256-w)*s + w*last is rewritten as 256*s + w*(last-s): one multiplier.
    // Weights above one clamp to one so the filter holds its last value.
    always_comb
    begin
        weight_eff = (filter_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : filter_weight_reg;
        diff = {last_filtered_reg[15], last_filtered_reg} - {sample_reg[15], sample_reg};
        prod = $signed({1'b0, weight_eff}) * diff;
        // Add half an LSB, then floor by the arithmetic shift: ties round up.
        sum  = {{3{sample_reg[15]}}, sample_reg, 8'd0} + prod + 27'sd128;
        // The result is a weighted mean of two 16-bit values, so it fits.
        last_filtered_next = sum[23:8];
    end

    // ---------------- evidence counter ----------------
    always_comb
    begin
        limit_ext = {2'b00, count_limit_reg};
        if (last_filtered_next > threshold_near_reg)
        begin
            // ground seen: back off if airborne, else forget all evidence
            if (flag_reg)
                cnt_step = {2'b00, count_reg} - {2'b00, landing_drop_reg};
            else
                cnt_step = '0;
        end
        else if (last_filtered_next > threshold_mid_reg)
            cnt_step = {2'b00, count_reg} + GROW_MID;
        else if (last_filtered_next > threshold_far_reg)
            cnt_step = {2'b00, count_reg} + GROW_FAR;
        else
            cnt_step = {2'b00, count_reg} + GROW_DEEP;

        // saturate at the limit and raise the flag there
        if (cnt_step >= limit_ext)
        begin
            flag_next = 1'b1;
            cnt_sat   = limit_ext;
        end
        else
        begin
            flag_next = 1'b0;
            cnt_sat   = cnt_step;
        end

        // clamp a landing drop that went below zero
        if (cnt_sat < 0)
            count_next = '0;
        else
            count_next = cnt_sat[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_filtered_reg <= '0;
            count_reg         <= '0;
            flag_reg          <= 1'b0;
        end
        else if (advance)
        begin
            last_filtered_reg <= last_filtered_next;
            count_reg         <= count_next;
            flag_reg          <= flag_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            filtered_g_reg     <= last_filtered_next;
            off_ground_reg     <= flag_next;
            evidence_count_reg <= count_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_g     = filtered_g_reg;
    assign off_ground     = off_ground_reg;
    assign evidence_count = evidence_count_reg;

endmodule

[rtl/ogd_checker.sv]
// Port-level checks for the off-ground detector, bound to the core.
// Depends on ogd_pkg and off_ground_detector_core_macros.svh.
`include "off_ground_detector_core_macros.svh"

module ogd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input ogd_pkg::sample_t    filtered_g,
    input logic                off_ground,
    input ogd_pkg::count_t     evidence_count
);

    import ogd_pkg::*;

    // A stalled result holds still.
    `OGD_ASSERT_NXT(a_result_held, out_valid && out_stall, out_valid && $stable(filtered_g) && $stable(off_ground) && $stable(evidence_count))

    // Requests back up only behind a stalled result.
    `OGD_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

    // A fresh result traces back to an accepted request.
    `OGD_ASSERT_IMP(a_result_origin, $rose(out_valid), $past(in_valid && !in_stall, 2))

    // Evidence grows by at most ten between consecutive results.
    `OGD_ASSERT_IMP(a_count_growth, out_valid && !out_stall && $past(out_valid && !out_stall), {1'b0, evidence_count} <= {1'b0, $past(evidence_count)} + 9'd10)

endmodule

bind off_ground_detector_core ogd_checker u_ogd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_g     (filtered_g),
    .off_ground     (off_ground),
    .evidence_count (evidence_count)
);
